@@ design/iol_pkg.sv @@
// Shared types, codes and defaults for the indexed ordered list.
package iol_pkg;

    localparam int DEF_CAPACITY   = 16;
    localparam int DEF_DATA_WIDTH = 32;

    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 5;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_INSERT = 3'd1,
        OP_POP    = 3'd2,
        OP_REMOVE = 3'd3,
        OP_SEARCH = 3'd4,
        OP_CLEAR  = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_POS   = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_INS_CHK,
        S_INS_WR,
        S_FETCH,
        S_EXAM,
        S_SHIFT_CHK,
        S_SHIFT_WR,
        S_FINISH
    } state_t;

endpackage

@@ design/iol_mem.sv @@
// Entry storage: one write port, one registered read port.
module iol_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ design/indexed_ordered_list.sv @@
// Top level of the indexed ordered list: sequencer, index unit and result register.
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | op, position, word_in
//  out     | output    | out_valid / out_ready | status, word_out, length
//
//  Insert, pop and remove walk the list element by element, and every element
//  step goes through the one index adder and the single read and write port
//  of the entry memory.
//  Reset clears the length and the sequencer; entry contents are not cleared.
//  A finished result waits in the output register while the next transfer is taken.
module indexed_ordered_list
#(
    parameter int CAPACITY   = iol_pkg::DEF_CAPACITY,
    parameter int DATA_WIDTH = iol_pkg::DEF_DATA_WIDTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [iol_pkg::OP_W-1:0]      op,
    input  logic [iol_pkg::POS_W-1:0]     position,
    input  logic [iol_pkg::WORD_W-1:0]    word_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [iol_pkg::STATUS_W-1:0]  status,
    output logic [iol_pkg::WORD_W-1:0]    word_out,
    output logic [iol_pkg::LEN_W-1:0]     length
);

    import iol_pkg::*;

    localparam int AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    state_t state_reg, state_next;

    op_t                 op_reg;
    logic [POS_W-1:0]    pos_reg;
    logic [DATA_WIDTH-1:0] word_reg;

    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    status_t             status_reg, status_next;
    logic [DATA_WIDTH-1:0] result_reg, result_next;

    logic                out_valid_reg;
    status_t             status_out_reg;
    logic [WORD_W-1:0]   word_out_reg;
    logic [LEN_W-1:0]    length_reg;

    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [AW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    logic          dir_down;
    logic [CW-1:0] idx_adj;
    logic          cnt_full;
    logic          pos_gt;
    logic          pos_ge;
    logic          idx_at_pos;
    logic          adj_ge_cnt;
    logic          word_match;
    logic          load_out;
    logic          in_xfer;

    iol_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // shared index unit: one adder stepping up or down, one compare against length
    assign dir_down   = (state_reg == S_INS_CHK) || (state_reg == S_INS_WR);
    assign idx_adj    = dir_down ? (idx_reg - ONE_C) : (idx_reg + ONE_C);
    assign adj_ge_cnt = idx_adj >= count_reg;

    assign cnt_full   = count_reg == CAP_C;
    assign pos_gt     = CMPW'(pos_reg) > CMPW'(count_reg);
    assign pos_ge     = CMPW'(pos_reg) >= CMPW'(count_reg);
    assign idx_at_pos = CMPW'(idx_reg) == CMPW'(pos_reg);
    assign word_match = mem_rdata == word_reg;

    assign in_ready = state_reg == S_IDLE;
    assign in_xfer  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (op_reg)
                    OP_INSERT: state_next = (pos_gt || cnt_full) ? S_FINISH : S_INS_CHK;
                    OP_POP,
                    OP_SEARCH: state_next = pos_ge ? S_FINISH : S_FETCH;
                    OP_REMOVE: state_next = (count_reg == '0) ? S_FINISH : S_FETCH;
                    default:   state_next = S_FINISH;
                endcase
            end
            S_INS_CHK:   state_next = idx_at_pos ? S_FINISH : S_INS_WR;
            S_INS_WR:    state_next = S_INS_CHK;
            S_FETCH:     state_next = S_EXAM;
            S_EXAM:
            begin
                case (op_reg)
                    OP_POP:    state_next = S_SHIFT_CHK;
                    OP_REMOVE:
                    begin
                        if (word_match)
                        begin
                            state_next = S_SHIFT_CHK;
                        end
                        else
                        begin
                            state_next = adj_ge_cnt ? S_FINISH : S_FETCH;
                        end
                    end
                    default:   state_next = S_FINISH;
                endcase
            end
            S_SHIFT_CHK: state_next = adj_ge_cnt ? S_FINISH : S_SHIFT_WR;
            S_SHIFT_WR:  state_next = S_SHIFT_CHK;
            S_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        count_next  = count_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        result_next = result_reg;
        mem_we      = 1'b0;
        mem_waddr   = idx_reg[AW-1:0];
        mem_wdata   = word_reg;
        mem_raddr   = idx_adj[AW-1:0];
        load_out    = 1'b0;
        case (state_reg)
            S_DISPATCH:
            begin
                status_next = ST_OK;
                result_next = '0;
                case (op_reg)
                    OP_PUSH:
                    begin
                        if (cnt_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = count_reg[AW-1:0];
                            count_next = count_reg + ONE_C;
                        end
                    end
                    OP_INSERT:
                    begin
                        if (pos_gt)
                        begin
                            status_next = ST_BAD_POS;
                        end
                        else if (cnt_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            idx_next = count_reg;
                        end
                    end
                    OP_POP,
                    OP_SEARCH:
                    begin
                        if (pos_ge)
                        begin
                            status_next = ST_BAD_POS;
                        end
                        else
                        begin
                            idx_next = CW'(pos_reg);
                        end
                    end
                    OP_REMOVE:
                    begin
                        status_next = ST_NOT_FOUND;
                        idx_next    = '0;
                    end
                    OP_CLEAR:
                    begin
                        count_next = '0;
                    end
                    default:
                    begin
                        status_next = ST_OK;
                    end
                endcase
            end
            S_INS_CHK:
            begin
                if (idx_at_pos)
                begin
                    mem_we     = 1'b1;
                    count_next = count_reg + ONE_C;
                end
            end
            S_INS_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                idx_next  = idx_adj;
            end
            S_FETCH:
            begin
                mem_raddr = idx_reg[AW-1:0];
            end
            S_EXAM:
            begin
                case (op_reg)
                    OP_POP,
                    OP_SEARCH:
                    begin
                        result_next = mem_rdata;
                    end
                    OP_REMOVE:
                    begin
                        if (word_match)
                        begin
                            result_next = mem_rdata;
                            status_next = ST_OK;
                        end
                        else
                        begin
                            idx_next = idx_adj;
                        end
                    end
                    default:
                    begin
                        result_next = result_reg;
                    end
                endcase
            end
            S_SHIFT_CHK:
            begin
                if (adj_ge_cnt)
                begin
                    count_next = count_reg - ONE_C;
                end
            end
            S_SHIFT_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                idx_next  = idx_adj;
            end
            S_FINISH:
            begin
                load_out = !out_valid_reg || out_ready;
            end
            default:
            begin
                load_out = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg   <= op_t'(op);
            pos_reg  <= position;
            word_reg <= DATA_WIDTH'(word_in);
        end
        idx_reg    <= idx_next;
        status_reg <= status_next;
        result_reg <= result_next;
        if (load_out)
        begin
            status_out_reg <= status_reg;
            word_out_reg   <= WORD_W'(result_reg);
            length_reg     <= LEN_W'(count_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = status_out_reg;
    assign word_out  = word_out_reg;
    assign length    = length_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_C)
        else $error("length above capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> (word_out == '0))
        else $error("nonzero word on failed request");

    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (CW'(mem_waddr) < CAP_C) && (CW'(mem_waddr) <= count_reg))
        else $error("entry write outside the list");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transfer taken while busy");

endmodule
